// File: rtl/core/http_request_header_parser_assert.svh
// Assertion macros used by the result queue of the header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

// File: rtl/core/hrp_pkg.sv
// Shared types, character codes and header name tables of the header parser.
`default_nettype none

package hrp_pkg;

  localparam int unsigned HRP_FIFO_DEPTH = 4;
  localparam int unsigned HRP_NUM_NAMES  = 12;

  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_LC    = 8'h63;

  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;

  localparam logic [3:0] FLD_URL     = 4'd0;
  localparam logic [3:0] FLD_VERSION = 4'd1;
  localparam logic [3:0] FLD_LAST    = 4'd12;
  localparam logic [3:0] FLD_CONN    = 4'd13;
  localparam logic [3:0] FLD_NONE    = 4'd15;

  typedef enum logic [2:0] {
    KIND_VALUE      = 3'd0,
    KIND_LINE_DONE  = 3'd1,
    KIND_HDR_DONE   = 3'd2,
    KIND_BAD_METHOD = 3'd3,
    KIND_NO_CR      = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] field;
    logic [7:0] value;
    logic [1:0] method;
    logic       keep_alive;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  typedef logic [0:15][7:0] name_t;

  localparam name_t HRP_NAME_TAB [HRP_NUM_NAMES] = '{
    {"Accept", 80'h0},
    {"Accept-encoding", 8'h0},
    {"Accept-language", 8'h0},
    {"Accept-charset", 16'h0},
    {"Authorization", 24'h0},
    {"Cache-Control", 24'h0},
    {"Connection", 48'h0},
    {"Cookie", 80'h0},
    {"Host", 96'h0},
    {"Referer", 72'h0},
    {"Upgrade", 72'h0},
    {"User-Agent", 48'h0}
  };

  localparam logic [3:0] HRP_NAME_LEN [HRP_NUM_NAMES] = '{
    4'd6, 4'd15, 4'd15, 4'd14, 4'd13, 4'd13, 4'd10, 4'd6, 4'd4, 4'd7, 4'd7, 4'd10
  };

  localparam logic [3:0] HRP_NAME_CODE [HRP_NUM_NAMES] = '{
    4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, FLD_CONN, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12
  };

endpackage

`default_nettype wire

// File: rtl/core/hrp_parser.sv
// Per-byte request parser: parser state registers and the single-pass step logic.
`default_nettype none

module hrp_parser
  import hrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       start_i,
  output res_pair_t       res_o
);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_BAD,
    PH_URL,
    PH_VER,
    PH_VTAIL,
    PH_HEADER,
    PH_IDLE
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  method;
    logic        keep_alive;
    logic [3:0]  line_pos;
    logic        colon_seen;
    logic [11:0] match;
    logic [3:0]  cur_field;
    logic [3:0]  prev_field;
    logic        skipping;
    logic        cr_pending;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic       emit;
    logic [3:0] fld;
  } step_t;

  localparam st_t ST_RESET = '{
    phase:      PH_METHOD,
    method:     METH_NONE,
    keep_alive: 1'b1,
    line_pos:   4'd0,
    colon_seen: 1'b0,
    match:      12'hFFF,
    cur_field:  FLD_NONE,
    prev_field: FLD_NONE,
    skipping:   1'b0,
    cr_pending: 1'b0
  };

  st_t st_q, st_d;

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT);
  endfunction

  function automatic st_t line_init(st_t s);
    st_t r;
    r            = s;
    r.line_pos   = 4'd0;
    r.colon_seen = 1'b0;
    r.match      = 12'hFFF;
    r.cur_field  = FLD_NONE;
    r.skipping   = 1'b0;
    r.cr_pending = 1'b0;
    return r;
  endfunction

  function automatic step_t header_byte(st_t s, logic [7:0] b);
    step_t      r;
    logic [3:0] k;
    logic [3:0] f;
    logic       found;
    r.st  = s;
    r.emit = 1'b0;
    r.fld  = s.cur_field;
    k     = s.line_pos;
    f     = FLD_NONE;
    found = 1'b0;
    if ((k == 4'd0) && is_blank(b)) begin
      r.st.cur_field  = s.prev_field;
      r.st.colon_seen = 1'b1;
      r.st.skipping   = 1'b1;
    end else if (!s.colon_seen) begin
      if (b == CH_COLON) begin
        for (int i = 0; i < HRP_NUM_NAMES; i++) begin
          if (!found && s.match[i] && (HRP_NAME_LEN[i] <= k)) begin
            f     = HRP_NAME_CODE[i];
            found = 1'b1;
          end
        end
        r.st.cur_field  = f;
        r.st.prev_field = f;
        r.st.colon_seen = 1'b1;
        r.st.skipping   = 1'b1;
      end else begin
        for (int i = 0; i < HRP_NUM_NAMES; i++) begin
          if (k < HRP_NAME_LEN[i]) begin
            if (HRP_NAME_TAB[i][k] != b) begin
              r.st.match[i] = 1'b0;
            end
          end else if (i == 0) begin
            r.st.match[i] = 1'b0;
          end
        end
      end
    end else if (!(s.skipping && is_blank(b))) begin
      if (s.skipping) begin
        r.st.skipping = 1'b0;
        if ((s.cur_field == FLD_CONN) && (b == CH_LC)) begin
          r.st.keep_alive = 1'b0;
        end
      end
      r.emit = (s.cur_field <= FLD_LAST);
    end
    if (s.line_pos != 4'd15) begin
      r.st.line_pos = s.line_pos + 4'd1;
    end
    return r;
  endfunction

  function automatic step_t data_byte(st_t s, logic [7:0] b);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.fld  = (s.phase == PH_URL) ? FLD_URL : FLD_VERSION;
    priority case (s.phase)
      PH_URL, PH_VER: begin
        if (s.skipping) begin
          if (!is_blank(b)) begin
            r.st.skipping = 1'b0;
            r.emit        = 1'b1;
          end
        end else if (is_blank(b)) begin
          if (s.phase == PH_URL) begin
            r.st.phase    = PH_VER;
            r.st.skipping = 1'b1;
          end else begin
            r.st.phase = PH_VTAIL;
          end
        end else begin
          r.emit = 1'b1;
        end
      end
      PH_HEADER: r = header_byte(s, b);
      default: r = r;
    endcase
    return r;
  endfunction

  always_comb begin
    st_t     s;
    step_t   s1;
    step_t   s2;
    logic    ok;
    logic    spec;
    kind_e   spec_kind;
    logic [1:0] spec_meth;
    result_t ra;
    result_t rb;

    s         = start_i ? ST_RESET : st_q;
    st_d      = s;
    s1        = '{st: s, emit: 1'b0, fld: FLD_NONE};
    s2        = '{st: s, emit: 1'b0, fld: FLD_NONE};
    ok        = 1'b0;
    spec      = 1'b0;
    spec_kind = KIND_VALUE;
    spec_meth = s.method;

    priority case (s.phase)
      PH_METHOD: begin
        if (byte_i == CH_LF) begin
          st_d.method = METH_NONE;
          st_d.phase  = PH_IDLE;
          spec        = 1'b1;
          spec_kind   = KIND_BAD_METHOD;
          spec_meth   = METH_NONE;
        end else begin
          priority case (s.line_pos)
            4'd0: begin
              if (byte_i == CH_UG) begin
                st_d.method = METH_GET;
                ok          = 1'b1;
              end else if (byte_i == CH_UH) begin
                st_d.method = METH_HEAD;
                ok          = 1'b1;
              end
            end
            4'd1: ok = (byte_i == CH_UE);
            4'd2: begin
              if ((s.method == METH_GET) && (byte_i == CH_UT)) begin
                st_d.phase    = PH_URL;
                st_d.skipping = 1'b1;
                ok            = 1'b1;
              end else begin
                ok = (s.method == METH_HEAD) && (byte_i == CH_UA);
              end
            end
            4'd3: begin
              if ((s.method == METH_HEAD) && (byte_i == CH_UD)) begin
                st_d.phase    = PH_URL;
                st_d.skipping = 1'b1;
                ok            = 1'b1;
              end
            end
            default: ok = 1'b0;
          endcase
          if (!ok) begin
            st_d.method = METH_NONE;
            st_d.phase  = PH_BAD;
          end else if (st_d.phase == PH_METHOD) begin
            st_d.line_pos = s.line_pos + 4'd1;
          end
        end
      end
      PH_BAD: begin
        if (byte_i == CH_LF) begin
          st_d.phase = PH_IDLE;
          spec       = 1'b1;
          spec_kind  = KIND_BAD_METHOD;
          spec_meth  = METH_NONE;
        end
      end
      PH_IDLE: st_d = s;
      default: begin
        if (byte_i == CH_LF) begin
          spec = 1'b1;
          if (!s.cr_pending) begin
            spec_kind  = KIND_NO_CR;
            st_d.phase = PH_IDLE;
          end else if (s.phase != PH_HEADER) begin
            spec_kind  = KIND_LINE_DONE;
            st_d       = line_init(s);
            st_d.phase = PH_HEADER;
          end else if (s.line_pos == 4'd0) begin
            spec_kind  = KIND_HDR_DONE;
            st_d.phase = PH_IDLE;
          end else begin
            spec = 1'b0;
            st_d = line_init(s);
          end
          st_d.cr_pending = 1'b0;
        end else begin
          if (s.cr_pending) begin
            s1.st.cr_pending = 1'b0;
            s1 = data_byte(s1.st, CH_CR);
          end
          if (byte_i == CH_CR) begin
            st_d            = s1.st;
            st_d.cr_pending = 1'b1;
          end else begin
            s2   = data_byte(s1.st, byte_i);
            st_d = s2.st;
          end
        end
      end
    endcase

    ra = '{kind: KIND_VALUE, field: 4'd0, value: 8'd0, method: s.method,
           keep_alive: s.keep_alive, last: 1'b0};
    rb = ra;
    res_o.cnt = 2'd0;
    if (spec) begin
      ra.kind   = spec_kind;
      ra.method = spec_meth;
      ra.last   = 1'b1;
      res_o.cnt = 2'd1;
    end else if (s1.emit && s2.emit) begin
      ra.field  = s1.fld;
      ra.value  = CH_CR;
      rb.field  = s2.fld;
      rb.value  = byte_i;
      rb.last   = 1'b1;
      res_o.cnt = 2'd2;
    end else if (s1.emit) begin
      ra.field  = s1.fld;
      ra.value  = CH_CR;
      ra.last   = 1'b1;
      res_o.cnt = 2'd1;
    end else if (s2.emit) begin
      ra.field  = s2.fld;
      ra.value  = byte_i;
      ra.last   = 1'b1;
      res_o.cnt = 2'd1;
    end
    if (!en_i) begin
      res_o.cnt = 2'd0;
    end
    res_o.r0 = ra;
    res_o.r1 = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hrp_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_stall_i is low.
`default_nettype none

module hrp_result_fifo
  import hrp_pkg::*;
#(
  parameter int unsigned Depth = HRP_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire res_pair_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output result_t         head_o
);

  `include "http_request_header_parser_assert.svh"

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= CW'(Depth - 2));
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.cnt == 2'd1) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end else if (push_i.cnt == 2'd2) begin
      wr_ptr_d = ptr_inc(ptr_inc(wr_ptr_q));
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[ptr_inc(wr_ptr_q)] <= push_i.r1;
    end
  end

  `HRP_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i.cnt != 2'd0, room_o)
  `HRP_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(Depth))
  `HRP_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && (push_i.cnt == 2'd0), cnt_q == $past(cnt_q) - 1'b1)

endmodule

`default_nettype wire

// File: rtl/core/http_request_header_parser.sv
// Top level of the request header parser: input register, parser and result queue.
//
// Usage: request bytes enter on the input channel (in_valid_i, in_stall_o,
// data_byte_i, start_request_i); a byte is taken at a rising edge with
// in_valid_i high and in_stall_o low. start_request_i on a byte clears the
// parser state before that byte is parsed. Each byte gives zero, one or two
// results on the output channel (out_valid_o, out_stall_i and the result
// ports); a result is taken at a rising edge with out_valid_o high and
// out_stall_i low, and last_of_run_o marks the final result of a byte.
// Data path: a taken byte is held in the input register, parsed there once the
// result queue has room, and its results are written into the queue, whose
// head drives the result ports. Throughput: one byte per cycle while the
// queue has room, set by the parser step. A byte that gives two results
// uses the one-result-per-cycle output once per result; several such bytes
// fill the queue, and in_stall_o stays high until two slots are free again.
// Reset puts the parser in the method phase with keep-alive set and empties
// the input register and the queue. When the receiver stalls, the queue
// holds results and the input side stalls once the queue is nearly full.
`default_nettype none

module http_request_header_parser
  import hrp_pkg::*;
#(
  parameter int unsigned FifoDepth = HRP_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       start_request_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      result_kind_o,
  output logic [3:0]      field_code_o,
  output logic [7:0]      value_byte_o,
  output logic [1:0]      method_code_o,
  output logic            keep_alive_o,
  output logic            last_of_run_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       room;
  logic       advance;
  res_pair_t  res;
  result_t    head;

  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_request_i;
    end
  end

  hrp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .res_o   (res)
  );

  hrp_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign result_kind_o = head.kind;
  assign field_code_o  = head.field;
  assign value_byte_o  = head.value;
  assign method_code_o = head.method;
  assign keep_alive_o  = head.keep_alive;
  assign last_of_run_o = head.last;

endmodule

`default_nettype wire
